// ----- src/idfl_pkg.sv -----
`default_nettype none

package idfl_pkg;

  // Identifier width and free list geometry.
  localparam int unsigned ID_W       = 32;
  localparam int unsigned CTR_W      = ID_W + 1;
  localparam int unsigned FREE_DEPTH = 1024;
  localparam int unsigned PTR_W      = $clog2(FREE_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FREE_DEPTH + 1);

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FREE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FREE_DEPTH);

  // Configuration port geometry and register indexes.
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_LOWEST_ID  = 1'b0;
  localparam logic REG_HIGHEST_ID = 1'b1;

  localparam logic [ID_W-1:0] LOWEST_ID_RST  = ID_W'(1);
  localparam logic [ID_W-1:0] HIGHEST_ID_RST = '1;

  // Request kinds.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_FREED     = 2'd2,
    ST_DROPPED   = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } ctrl_state_e;

  // One finished result on its way to the output buffer.
  typedef struct packed {
    logic            vld;
    logic [ID_W-1:0] id;
    status_e         status;
  } result_t;

  // Configuration seen by the sequencer.
  typedef struct packed {
    logic            load_lowest;
    logic [ID_W-1:0] lowest_id;
    logic [ID_W-1:0] highest_id;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/idfl_ram.sv -----
`default_nettype none

module idfl_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/idfl_ctrl.sv -----
`default_nettype none

module idfl_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire idfl_pkg::cfg_t               cfg_i,
  input  wire logic                         req_i,
  input  wire logic                         action_i,
  input  wire logic [idfl_pkg::ID_W-1:0]    freed_id_i,
  output logic                              busy_o,
  output idfl_pkg::result_t                 res_o
);

  idfl_pkg::ctrl_state_e state_q, state_d;

  logic [idfl_pkg::CTR_W-1:0] fresh_q, fresh_d;
  logic [idfl_pkg::PTR_W-1:0] head_q, head_d;
  logic [idfl_pkg::PTR_W-1:0] tail_q, tail_d;
  logic [idfl_pkg::CNT_W-1:0] count_q, count_d;

  logic                        ram_we;
  logic                        ram_re;
  logic [idfl_pkg::ID_W-1:0]   ram_rdata;

  logic fresh_ok;
  logic list_empty;
  logic list_full;

  assign fresh_ok   = fresh_q <= {1'b0, cfg_i.highest_id};
  assign list_empty = count_q == '0;
  assign list_full  = count_q == idfl_pkg::CNT_FULL;
  assign busy_o     = state_q != idfl_pkg::S_IDLE;

  // Free list storage. Each request touches at most one entry and requests
  // are taken one at a time, so a read never overlaps a write to its entry.
  idfl_ram #(
    .DEPTH (idfl_pkg::FREE_DEPTH),
    .WIDTH (idfl_pkg::ID_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (freed_id_i),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Next state: a dequeue from the free list waits in S_READ for the registered memory read.
  always_comb begin
    state_d = state_q;
    case (state_q)
      idfl_pkg::S_IDLE: begin
        if (req_i && action_i == idfl_pkg::ACT_ALLOC && !fresh_ok && !list_empty) begin
          state_d = idfl_pkg::S_READ;
        end
      end
      idfl_pkg::S_READ: begin
        state_d = idfl_pkg::S_IDLE;
      end
      default: begin
        state_d = idfl_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs: counter, pointers, memory strobes and the result.
  always_comb begin
    fresh_d    = fresh_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    res_o      = '0;
    res_o.status = idfl_pkg::ST_ALLOCATED;
    case (state_q)
      idfl_pkg::S_IDLE: begin
        if (req_i) begin
          if (action_i == idfl_pkg::ACT_ALLOC) begin
            if (fresh_ok) begin
              res_o.vld    = 1'b1;
              res_o.id     = fresh_q[idfl_pkg::ID_W-1:0];
              res_o.status = idfl_pkg::ST_ALLOCATED;
              fresh_d      = fresh_q + idfl_pkg::CTR_W'(1);
            end else if (!list_empty) begin
              // The result follows once the memory returns the entry.
              ram_re  = 1'b1;
              head_d  = (head_q == idfl_pkg::PTR_LAST) ? '0 : head_q + idfl_pkg::PTR_W'(1);
              count_d = count_q - idfl_pkg::CNT_W'(1);
            end else begin
              res_o.vld    = 1'b1;
              res_o.status = idfl_pkg::ST_EXHAUSTED;
            end
          end else begin
            if (!list_full) begin
              ram_we       = 1'b1;
              tail_d       = (tail_q == idfl_pkg::PTR_LAST) ? '0 : tail_q + idfl_pkg::PTR_W'(1);
              count_d      = count_q + idfl_pkg::CNT_W'(1);
              res_o.vld    = 1'b1;
              res_o.status = idfl_pkg::ST_FREED;
            end else begin
              res_o.vld    = 1'b1;
              res_o.status = idfl_pkg::ST_DROPPED;
            end
          end
        end
      end
      idfl_pkg::S_READ: begin
        // A queued id of zero still means that no id is available.
        res_o.vld    = 1'b1;
        res_o.id     = ram_rdata;
        res_o.status = (ram_rdata != '0) ? idfl_pkg::ST_ALLOCATED : idfl_pkg::ST_EXHAUSTED;
      end
      default: begin
        res_o.vld = 1'b0;
      end
    endcase
    // Writing lowest_id reloads the fresh counter.
    if (cfg_i.load_lowest) begin
      fresh_d = {1'b0, cfg_i.lowest_id};
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idfl_pkg::S_IDLE;
      fresh_q <= {1'b0, idfl_pkg::LOWEST_ID_RST};
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      fresh_q <= fresh_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  // The fill count never passes the list depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= idfl_pkg::CNT_FULL)
    else $error("free list count exceeds depth");

  // A memory read is answered in the very next cycle.
  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == idfl_pkg::S_READ |=> state_q == idfl_pkg::S_IDLE)
    else $error("read state lasted more than one cycle");

  // A dequeue has taken one entry off the list.
  a_read_dequeued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == idfl_pkg::S_READ) |-> count_q == $past(count_q) - idfl_pkg::CNT_W'(1))
    else $error("dequeue did not decrement the fill count");

  // No new request arrives while a dequeue is in flight.
  a_no_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !req_i)
    else $error("request taken while busy");
`endif

endmodule

`default_nettype wire

// ----- src/idfl_out_buf.sv -----
`default_nettype none

module idfl_out_buf (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire idfl_pkg::result_t            res_i,
  input  wire logic                         out_stall_i,
  output logic                              full_o,
  output logic                              out_valid_o,
  output logic [idfl_pkg::ID_W-1:0]         given_id_o,
  output logic [1:0]                        status_o
);

  logic              out_valid_q;
  logic              skid_valid_q;
  idfl_pkg::result_t out_q;
  idfl_pkg::result_t skid_q;
  logic              out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign given_id_o  = out_q.id;
  assign status_o    = out_q.status;

  // Valid bits of the output register and the skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || res_i.vld;
      skid_valid_q <= skid_valid_q && res_i.vld;
    end else if (res_i.vld) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload: the older result always moves to the output first.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (res_i.vld) begin
          skid_q <= res_i;
        end
      end else if (res_i.vld) begin
        out_q <= res_i;
      end
    end else if (res_i.vld) begin
      skid_q <= res_i;
    end
  end

`ifndef NO_ASSERTIONS
  // The skid stage only holds a result behind a waiting one.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result with the output empty");

  // A result never arrives while both stages are occupied and the output stalls.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_i.vld && skid_valid_q && out_stall_i))
    else $error("result arrived with the buffer full");

  // A drained output with a skid result stays valid with that result.
  a_skid_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_stall_i |=> out_valid_q)
    else $error("skid result was lost");
`endif

endmodule

`default_nettype wire

// ----- src/id_allocator_free_list_unit.sv -----
`default_nettype none

// Identifier allocator. An allocate request gets the next fresh id from a
// counter running from lowest_id up to highest_id; once the counter is past
// highest_id, ids come from a first-in first-out free list of 1024 entries
// held in one synchronous memory. A free request queues its id, or reports
// that it was dropped when the list is full. Each request gives one result:
// given_id (0 on exhaustion and on every free) and status. Allocations from
// the counter, exhaustion answers and frees hand their result to the output
// buffer in the cycle they are taken; an allocation from the free list waits
// in a read state for the registered free-list memory read. A two-entry
// output buffer lets the next request enter while a result waits. The memory
// needs no clearing after reset. Writing lowest_id reloads the fresh counter.
// The user writes configuration only while the block is idle; it is unchecked.
module id_allocator_free_list_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [idfl_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  // Request channel.
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          action_i,
  input  wire logic [idfl_pkg::ID_W-1:0]     freed_id_i,
  // Result channel.
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [idfl_pkg::ID_W-1:0]          given_id_o,
  output logic [1:0]                         status_o
);

  logic [idfl_pkg::ID_W-1:0] lowest_q;
  logic [idfl_pkg::ID_W-1:0] highest_q;
  logic                      cfg_wr;
  logic                      req;
  logic                      busy;
  logic                      buf_full;
  idfl_pkg::cfg_t            cfg;
  idfl_pkg::result_t         res;

  // Register access: always ready, index taken from the word address.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == idfl_pkg::REG_HIGHEST_ID) ? highest_q : lowest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q  <= idfl_pkg::LOWEST_ID_RST;
      highest_q <= idfl_pkg::HIGHEST_ID_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == idfl_pkg::REG_LOWEST_ID) begin
        lowest_q <= pwdata;
      end else begin
        highest_q <= pwdata;
      end
    end
  end

  assign cfg.load_lowest = cfg_wr && (paddr[2] == idfl_pkg::REG_LOWEST_ID);
  assign cfg.lowest_id   = pwdata;
  assign cfg.highest_id  = highest_q;

  // A request enters when no dequeue is in flight and the skid stage is free.
  assign in_stall_o = busy || buf_full;
  assign req        = in_valid_i && !in_stall_o;

  idfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .req_i      (req),
    .action_i   (action_i),
    .freed_id_i (freed_id_i),
    .busy_o     (busy),
    .res_o      (res)
  );

  idfl_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .given_id_o  (given_id_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire
